[hdl/ogm_pkg.sv]
package ogm_pkg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROT,
        ST_MUL,
        ST_SUM,
        ST_PREP,
        ST_DIV,
        ST_CHECK,
        ST_RD,
        ST_WB,
        ST_DONE
    } ogm_state_t;

    localparam logic [2:0] REG_START_ANGLE   = 3'd0;
    localparam logic [2:0] REG_ANGLE_STEP    = 3'd1;
    localparam logic [2:0] REG_HEADING_ANGLE = 3'd2;
    localparam logic [2:0] REG_ROBOT_ROW     = 3'd3;
    localparam logic [2:0] REG_ROBOT_COL     = 3'd4;
    localparam logic [2:0] REG_CELL_SIZE_MM  = 3'd5;

    localparam int NUM_W = 26;
    localparam int DEN_W = 16;

    localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;

    function automatic logic [29:0] ogm_atan(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

[hdl/lidar_scan_to_occupancy_grid_top.sv]
// Maps LiDAR range samples into a GRID_ROWS x GRID_COLS occupancy grid held in one
// single-port-write RAM. One request is handled at a time. A range sample runs
// CORDIC_STEPS (max 24) rotation steps, then the multiply, sum, prep, divide,
// check, cell read and write-back states; the read and write-back are skipped when
// the hit falls outside the grid. A sample with no return goes straight to done;
// a cell read runs only the read and write-back states. After reset, and at every
// sample flagged first_of_scan, the grid is cleared one cell per cycle, during
// which no request is taken.
// A finished result moves into an output register once the one before it has been
// delivered or is being delivered; the next request is taken after that move.
module lidar_scan_to_occupancy_grid_top
    import ogm_pkg::*;
#(
    parameter int GRID_ROWS    = 22,
    parameter int GRID_COLS    = 72,
    parameter int CORDIC_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [15:0] range_mm,
    input  logic        first_of_scan,
    input  logic [4:0]  query_row,
    input  logic [6:0]  query_col,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        marked,
    output logic [4:0]  hit_row,
    output logic [6:0]  hit_col,
    output logic        newly_marked,
    output logic        occupied
);

    localparam int DEPTH  = GRID_ROWS * GRID_COLS;
    localparam int AW     = $clog2(DEPTH);
    localparam int NSTEPS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;

    ogm_state_t state_reg, state_next;

    logic [23:0] start_angle_reg, angle_step_reg, heading_angle_reg;
    logic [4:0]  robot_row_reg;
    logic [6:0]  robot_col_reg;
    logic [15:0] cell_size_mm_reg;
    logic [23:0] beam_reg;

    logic        resume_reg, skip_reg, is_read_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic [AW-1:0] addr_reg;
    logic        qinb_reg;
    logic [15:0] range_reg;
    logic [1:0]  quad_reg;
    logic signed [32:0] x_reg, y_reg;
    logic signed [31:0] z_reg;
    logic [4:0]  i_reg;
    logic signed [49:0] prod_r_reg, prod_c_reg;
    logic [22:0] bp_r_reg, bp_c_reg;
    logic signed [55:0] n_r_reg, n_c_reg;
    logic        neg_r_reg, neg_c_reg;

    logic        res_marked_reg, res_newly_reg, res_occ_reg;
    logic [4:0]  res_row_reg;
    logic [6:0]  res_col_reg;

    logic        out_valid_reg;
    logic        out_marked_reg, out_newly_reg, out_occ_reg;
    logic [4:0]  out_row_reg;
    logic [6:0]  out_col_reg;

    logic        accept;
    logic [23:0] beam_next;
    logic [23:0] theta;
    logic [15:0] cell_eff;
    logic signed [32:0] c_val, s_val, x_sh, y_sh;
    logic signed [31:0] atan_v;
    logic [55:0] mag_r, mag_c;
    logic [56:0] numf_r, numf_c;
    logic        div_done_r, div_done_c;
    logic [NUM_W-1:0] quo_r, quo_c;
    logic        hit_inb;
    logic [15:0] hit_addr16, q_addr16;
    logic        q_inb;
    logic        ram_we;
    logic [AW-1:0] ram_waddr;
    logic        ram_wdata;
    logic        ram_rdata;
    logic        load_out;

    assign accept    = in_valid && in_ready;
    assign beam_next = first_of_scan ? start_angle_reg : 24'(beam_reg + angle_step_reg);
    assign theta     = 24'(beam_next - heading_angle_reg);
    assign cell_eff  = (cell_size_mm_reg == 16'd0) ? 16'd1 : cell_size_mm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_angle_reg   <= 24'd8388608;
            angle_step_reg    <= 24'd9992;
            heading_angle_reg <= 24'd0;
            robot_row_reg     <= 5'd10;
            robot_col_reg     <= 7'd30;
            cell_size_mm_reg  <= 16'd500;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_START_ANGLE:   start_angle_reg   <= cfg_data;
                REG_ANGLE_STEP:    angle_step_reg    <= cfg_data;
                REG_HEADING_ANGLE: heading_angle_reg <= cfg_data;
                REG_ROBOT_ROW:     robot_row_reg     <= cfg_data[4:0];
                REG_ROBOT_COL:     robot_col_reg     <= cfg_data[6:0];
                REG_CELL_SIZE_MM:  cell_size_mm_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    if (!resume_reg)
                        state_next = ST_IDLE;
                    else if (skip_reg)
                        state_next = ST_DONE;
                    else
                        state_next = ST_ROT;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (op)
                        state_next = ST_RD;
                    else if (first_of_scan)
                        state_next = ST_CLEAR;
                    else if (range_mm == 16'd0 || range_mm == 16'hFFFF)
                        state_next = ST_DONE;
                    else
                        state_next = ST_ROT;
                end
            end
            ST_ROT:
            begin
                if (i_reg == 5'(NSTEPS - 1))
                    state_next = ST_MUL;
            end
            ST_MUL:   state_next = ST_SUM;
            ST_SUM:   state_next = ST_PREP;
            ST_PREP:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_done_r)
                    state_next = ST_CHECK;
            end
            ST_CHECK: state_next = hit_inb ? ST_RD : ST_DONE;
            ST_RD:    state_next = ST_WB;
            ST_WB:    state_next = ST_DONE;
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // CORDIC step and quadrant fold
    assign x_sh   = x_reg >>> i_reg;
    assign y_sh   = y_reg >>> i_reg;
    assign atan_v = $signed({2'b00, ogm_atan(i_reg)});

    always_comb
    begin
        case (quad_reg)
            2'd0:    begin c_val = x_reg;  s_val = y_reg;  end
            2'd1:    begin c_val = -y_reg; s_val = x_reg;  end
            2'd2:    begin c_val = -x_reg; s_val = -y_reg; end
            default: begin c_val = y_reg;  s_val = -x_reg; end
        endcase
    end

    // rounding: q = floor((2|n| + d) / 2d), d = cell << 30
    assign mag_r  = n_r_reg[55] ? 56'(-n_r_reg) : 56'(n_r_reg);
    assign mag_c  = n_c_reg[55] ? 56'(-n_c_reg) : 56'(n_c_reg);
    assign numf_r = {mag_r, 1'b0} + {11'd0, cell_eff, 30'd0};
    assign numf_c = {mag_c, 1'b0} + {11'd0, cell_eff, 30'd0};

    ogm_div u_div_row (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_PREP),
        .num   (numf_r[56:31]),
        .den   (cell_eff),
        .done  (div_done_r),
        .quo   (quo_r)
    );

    ogm_div u_div_col (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_PREP),
        .num   (numf_c[56:31]),
        .den   (cell_eff),
        .done  (div_done_c),
        .quo   (quo_c)
    );

    assign hit_inb = (!neg_r_reg || quo_r == '0) && (quo_r < NUM_W'(GRID_ROWS))
                  && (!neg_c_reg || quo_c == '0) && (quo_c < NUM_W'(GRID_COLS));
    assign hit_addr16 = 16'(quo_r[7:0] * 16'(GRID_COLS)) + 16'(quo_c[7:0]);
    assign q_addr16   = 16'(query_row * 16'(GRID_COLS)) + 16'(query_col);
    assign q_inb      = (int'(query_row) < GRID_ROWS) && (int'(query_col) < GRID_COLS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beam_reg    <= 24'd0;
            clr_cnt_reg <= '0;
            resume_reg  <= 1'b0;
            skip_reg    <= 1'b0;
            is_read_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_CLEAR)
                clr_cnt_reg <= (clr_cnt_reg == AW'(DEPTH - 1)) ? '0 : clr_cnt_reg + 1'b1;
            if (accept)
            begin
                is_read_reg <= op;
                resume_reg  <= 1'b1;
                skip_reg    <= (range_mm == 16'd0 || range_mm == 16'hFFFF);
                if (!op)
                    beam_reg <= beam_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            range_reg      <= range_mm;
            quad_reg       <= theta[23:22];
            z_reg          <= $signed({2'b00, theta[21:0], 8'd0});
            x_reg          <= CORDIC_X0;
            y_reg          <= '0;
            i_reg          <= '0;
            addr_reg       <= q_addr16[AW-1:0];
            qinb_reg       <= q_inb;
            res_marked_reg <= 1'b0;
            res_newly_reg  <= 1'b0;
            res_occ_reg    <= 1'b0;
            res_row_reg    <= '0;
            res_col_reg    <= '0;
        end
        unique case (state_reg)
            ST_ROT:
            begin
                if (!z_reg[31])
                begin
                    x_reg <= x_reg - y_sh;
                    y_reg <= y_reg + x_sh;
                    z_reg <= z_reg - atan_v;
                end
                else
                begin
                    x_reg <= x_reg + y_sh;
                    y_reg <= y_reg - x_sh;
                    z_reg <= z_reg + atan_v;
                end
                i_reg <= i_reg + 1'b1;
            end
            ST_MUL:
            begin
                prod_r_reg <= $signed({1'b0, range_reg}) * c_val;
                prod_c_reg <= $signed({1'b0, range_reg}) * s_val;
                bp_r_reg   <= {2'b00, robot_row_reg} * cell_eff;
                bp_c_reg   <= robot_col_reg * cell_eff;
            end
            ST_SUM:
            begin
                n_r_reg <= $signed({3'b000, bp_r_reg, 30'd0}) + 56'(prod_r_reg);
                n_c_reg <= $signed({3'b000, bp_c_reg, 30'd0}) + 56'(prod_c_reg);
            end
            ST_PREP:
            begin
                neg_r_reg <= n_r_reg[55];
                neg_c_reg <= n_c_reg[55];
            end
            ST_CHECK:
            begin
                addr_reg <= hit_addr16[AW-1:0];
                if (hit_inb)
                begin
                    res_row_reg <= quo_r[4:0];
                    res_col_reg <= quo_c[6:0];
                end
            end
            ST_WB:
            begin
                if (is_read_reg)
                begin
                    res_occ_reg <= qinb_reg & ram_rdata;
                end
                else
                begin
                    res_marked_reg <= 1'b1;
                    res_newly_reg  <= !ram_rdata;
                end
            end
            default: ;
        endcase
    end

    assign ram_we    = (state_reg == ST_CLEAR) || (state_reg == ST_WB && !is_read_reg);
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : addr_reg;
    assign ram_wdata = (state_reg != ST_CLEAR);

    ogm_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_marked_reg <= res_marked_reg;
            out_newly_reg  <= res_newly_reg;
            out_occ_reg    <= res_occ_reg;
            out_row_reg    <= res_row_reg;
            out_col_reg    <= res_col_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign marked       = out_marked_reg;
    assign newly_marked = out_newly_reg;
    assign occupied     = out_occ_reg;
    assign hit_row      = out_row_reg;
    assign hit_col      = out_col_reg;

    a_no_req_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !in_ready)
        else $error("request taken during grid clear");

    a_newly_implies_marked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && newly_marked |-> marked)
        else $error("newly_marked without marked");

    a_unmarked_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !marked |-> hit_row == 5'd0 && hit_col == 7'd0 && !newly_marked)
        else $error("hit cell nonzero without mark");

    a_dividers_align: assert property (@(posedge clk) disable iff (!rst_n)
        div_done_r == div_done_c)
        else $error("row and column dividers out of step");

    a_read_no_mark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && occupied |-> !marked)
        else $error("read result carries a mark");

endmodule

[hdl/ogm_ram.sv]
module ogm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1584
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/ogm_div.sv]
module ogm_div
    import ogm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] acc_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, acc_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            acc_reg <= {acc_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = acc_reg;

endmodule
